FILE: hw/rtl/slk_pkg.sv
// Shared types and constants for the sorted key list unit.
// Used by slk_cell, slk_ctrl and sorted_key_list_unit; depends on nothing else.
package slk_pkg;

	localparam int CAPACITY = 64;
	localparam int KEY_W    = 32;
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	localparam int ROT_W    = $clog2(CAPACITY);

	localparam logic [1:0] CMD_INSERT    = 2'd0;
	localparam logic [1:0] CMD_DELETE    = 2'd1;
	localparam logic [1:0] CMD_LIST_UP   = 2'd2;
	localparam logic [1:0] CMD_LIST_DOWN = 2'd3;

	localparam logic [2:0] ST_INSERTED  = 3'd0;
	localparam logic [2:0] ST_DELETED   = 3'd1;
	localparam logic [2:0] ST_NOT_FOUND = 3'd2;
	localparam logic [2:0] ST_FULL      = 3'd3;
	localparam logic [2:0] ST_EMPTY     = 3'd4;

	typedef enum logic [2:0] {
		CELL_HOLD,
		CELL_INS,
		CELL_DEL,
		CELL_LEFT,
		CELL_RIGHT
	} cell_op_t;

	typedef struct packed {
		cell_op_t                 op;
		logic signed [KEY_W-1:0]  key;
	} cell_ctl_t;

endpackage

FILE: hw/rtl/slk_cell.sv
// One storage cell of the key chain: holds one key and moves it to or from its neighbors.
// Depends on slk_pkg.
module slk_cell import slk_pkg::*; (
	input  logic                    clk,
	input  cell_ctl_t               ctl,
	input  logic                    occupied,
	input  logic signed [KEY_W-1:0] prev_key,
	input  logic                    prev_ge,
	input  logic signed [KEY_W-1:0] next_key,
	output logic signed [KEY_W-1:0] stored_key,
	output logic                    ge,
	output logic                    match
);

	logic signed [KEY_W-1:0] key_q;

	// Free cells count as "not smaller", so the insert point never lies beyond them.
	assign ge         = !occupied || (key_q >= ctl.key);
	assign match      = occupied && (key_q == ctl.key);
	assign stored_key = key_q;

	always_ff @(posedge clk) begin
		unique case (ctl.op)
			CELL_HOLD: begin
				key_q <= key_q;
			end
			CELL_INS: begin
				if (ge) begin
					key_q <= prev_ge ? prev_key : ctl.key;
				end
			end
			CELL_DEL: begin
				if (ge) begin
					key_q <= next_key;
				end
			end
			CELL_LEFT: begin
				key_q <= next_key;
			end
			CELL_RIGHT: begin
				key_q <= prev_key;
			end
			default: begin
				key_q <= key_q;
			end
		endcase
	end

endmodule

FILE: hw/rtl/slk_ctrl.sv
// Sequencer of the sorted key list: command decode, entry count, listing rotation
// and the output register. Depends on slk_pkg.
module slk_ctrl import slk_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  logic [1:0]              command,
	input  logic signed [KEY_W-1:0] key,
	output logic                    out_valid,
	input  logic                    out_ready,
	output logic signed [KEY_W-1:0] out_key,
	output logic [2:0]              status,
	output logic                    is_entry,
	output logic                    last,
	input  logic                    found,
	input  logic signed [KEY_W-1:0] first_key,
	input  logic signed [KEY_W-1:0] final_key,
	output cell_ctl_t               cell_ctl,
	output logic [CNT_W-1:0]        count
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_OP,
		S_LIST
	} state_t;

	state_t                  state_q;
	logic [1:0]              cmd_q;
	logic signed [KEY_W-1:0] key_q;
	logic [CNT_W-1:0]        count_q;
	logic [ROT_W-1:0]        rot_q;
	logic                    out_valid_q;
	logic signed [KEY_W-1:0] out_key_q;
	logic [2:0]              status_q;
	logic                    is_entry_q;
	logic                    last_q;

	logic                    slot_free;
	logic                    full;
	logic                    ascending;
	logic [CNT_W:0]          rot_plus_count;
	logic                    emit;
	logic                    emit_last;
	logic                    list_step;
	logic                    out_load;

	assign slot_free = !out_valid_q || out_ready;
	assign full      = (count_q == CNT_W'(CAPACITY));
	assign ascending = (cmd_q == CMD_LIST_UP);

	// Ascending: cell 0 shows original slot rot, emitted while rot < count.
	// Descending: the last cell shows original slot CAPACITY-1-rot, emitted once that is
	// below count.
	assign rot_plus_count = (CNT_W+1)'(rot_q) + (CNT_W+1)'(count_q);
	always_comb begin
		if (ascending) begin
			emit      = (CNT_W'(rot_q) < count_q);
			emit_last = ((CNT_W+1)'(rot_q) + (CNT_W+1)'(1) == (CNT_W+1)'(count_q));
		end else begin
			emit      = (rot_plus_count >= (CNT_W+1)'(CAPACITY));
			emit_last = (rot_q == ROT_W'(CAPACITY - 1));
		end
	end
	assign list_step = (state_q == S_LIST) && (!emit || slot_free);

	// The result register takes a new item whenever a command step produces one.
	assign out_load = (state_q == S_OP && slot_free) || (list_step && emit);

	always_comb begin
		cell_ctl.key = key_q;
		cell_ctl.op  = CELL_HOLD;
		if (state_q == S_OP && slot_free) begin
			if (cmd_q == CMD_INSERT && !full) begin
				cell_ctl.op = CELL_INS;
			end else if (cmd_q == CMD_DELETE && found) begin
				cell_ctl.op = CELL_DEL;
			end
		end else if (list_step) begin
			cell_ctl.op = ascending ? CELL_LEFT : CELL_RIGHT;
		end
	end

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;
	assign out_key   = out_key_q;
	assign status    = status_q;
	assign is_entry  = is_entry_q;
	assign last      = last_q;
	assign count     = count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			rot_q       <= '0;
			out_valid_q <= 1'b0;
			cmd_q       <= CMD_INSERT;
			key_q       <= '0;
			out_key_q   <= '0;
			status_q    <= ST_INSERTED;
			is_entry_q  <= 1'b0;
			last_q      <= 1'b0;
		end else begin
			out_valid_q <= out_load || (out_valid_q && !out_ready);
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						cmd_q <= command;
						key_q <= key;
						rot_q <= '0;
						if ((command == CMD_LIST_UP || command == CMD_LIST_DOWN) &&
						    count_q != '0) begin
							state_q <= S_LIST;
						end else begin
							state_q <= S_OP;
						end
					end
				end
				S_OP: begin
					if (slot_free) begin
						is_entry_q  <= 1'b0;
						last_q      <= 1'b1;
						state_q     <= S_IDLE;
						unique case (cmd_q)
							CMD_INSERT: begin
								out_key_q <= key_q;
								if (full) begin
									status_q <= ST_FULL;
								end else begin
									status_q <= ST_INSERTED;
									count_q  <= count_q + CNT_W'(1);
								end
							end
							CMD_DELETE: begin
								out_key_q <= key_q;
								if (found) begin
									status_q <= ST_DELETED;
									count_q  <= count_q - CNT_W'(1);
								end else begin
									status_q <= ST_NOT_FOUND;
								end
							end
							CMD_LIST_UP, CMD_LIST_DOWN: begin
								out_key_q <= '0;
								status_q  <= ST_EMPTY;
							end
							default: begin
								out_key_q <= '0;
								status_q  <= ST_EMPTY;
							end
						endcase
					end
				end
				S_LIST: begin
					if (list_step) begin
						if (emit) begin
							out_key_q   <= ascending ? first_key : final_key;
							status_q    <= ST_INSERTED;
							is_entry_q  <= 1'b1;
							last_q      <= emit_last;
						end
						rot_q <= rot_q + ROT_W'(1);
						if (rot_q == ROT_W'(CAPACITY - 1)) begin
							state_q <= S_IDLE;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

FILE: hw/rtl/sorted_key_list_unit.sv
// Sorted key list unit: top level with the chain of key cells and its sequencer.
// Depends on slk_pkg, slk_cell and slk_ctrl.
//
// The unit keeps up to CAPACITY signed 32-bit keys in ascending order, duplicates
// allowed, in a row of cells where cell 0 holds the smallest key. An insert compares
// the key against every cell at once and shifts the entries not smaller one cell up in a
// single step; a delete finds the first equal entry the same way and closes the gap.
// Each insert or delete returns exactly one item (inserted, full, deleted or not found),
// registered from the S_OP state once the output register is free.
// A listing rotates the whole chain as a ring, one cell per cycle unless a key to be sent
// waits on a full output register, and sends out each stored key as it passes the end of
// the chain, ascending or descending, with last set on the final one; after a full turn
// the chain is back in place. A listing therefore occupies the unit for a full turn of the
// ring whatever the number of entries. A listing of an empty list gives one list-empty
// item. One command is handled at a time; the result register lets the next command be
// accepted while the last item waits.
module sorted_key_list_unit import slk_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  logic [1:0]              command,
	input  logic signed [KEY_W-1:0] key,
	output logic                    out_valid,
	input  logic                    out_ready,
	output logic signed [KEY_W-1:0] out_key,
	output logic [2:0]              status,
	output logic                    is_entry,
	output logic                    last
);

	cell_ctl_t               cell_ctl;
	logic [CNT_W-1:0]        count;
	logic signed [KEY_W-1:0] cell_key [CAPACITY];
	logic [CAPACITY-1:0]     cell_ge;
	logic [CAPACITY-1:0]     cell_match;
	logic                    found;

	// Any equal entry means the first cell at or above the key is the one to remove.
	assign found = |cell_match;

	slk_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.command   (command),
		.key       (key),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_key   (out_key),
		.status    (status),
		.is_entry  (is_entry),
		.last      (last),
		.found     (found),
		.first_key (cell_key[0]),
		.final_key (cell_key[CAPACITY-1]),
		.cell_ctl  (cell_ctl),
		.count     (count)
	);

	// The chain closes into a ring so that a listing can rotate every cell back home.
	for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
		localparam int PREV = (g == 0) ? CAPACITY - 1 : g - 1;
		localparam int NEXT = (g == CAPACITY - 1) ? 0 : g + 1;

		logic occupied;
		logic prev_ge;

		assign occupied = (CNT_W'(g) < count);
		// The first cell has no lower neighbor for an insert, so when it shifts it takes the new key itself.
		assign prev_ge  = (g == 0) ? 1'b0 : cell_ge[PREV];

		slk_cell u_cell (
			.clk        (clk),
			.ctl        (cell_ctl),
			.occupied   (occupied),
			.prev_key   (cell_key[PREV]),
			.prev_ge    (prev_ge),
			.next_key   (cell_key[NEXT]),
			.stored_key (cell_key[g]),
			.ge         (cell_ge[g]),
			.match      (cell_match[g])
		);
	end

	// The entry count never exceeds the number of cells.
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count <= CNT_W'(CAPACITY))
		else $error("entry count above capacity");

	// The chain only moves while a command is in progress.
	a_cells_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> cell_ctl.op == CELL_HOLD)
		else $error("cell chain moved while idle");

	// A listed entry always carries the plain status code.
	a_entry_status: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && is_entry |-> status == ST_INSERTED)
		else $error("listed entry with a non-zero status");

	// A full list cannot grow.
	a_full_holds: assert property (@(posedge clk) disable iff (!arst_n)
		count == CNT_W'(CAPACITY) |-> cell_ctl.op != CELL_INS)
		else $error("insert into a full list");

endmodule

FILE: tb/sv/sorted_key_list_unit_test.sv
// Self-checking testbench for sorted_key_list_unit: directed and random command streams.
// Keeps its own ordered copy of the key table and compares every output item in order.
// Depends on slk_pkg and the sorted_key_list_unit RTL only.
module sorted_key_list_unit_test;
	import slk_pkg::*;

	// Quiet cycles (nothing accepted on either side) tolerated before the run is declared hung.
	// A listing rotates the whole ring, so the ring can keep turning between output items with
	// nothing accepted on either side, even without stalls; random idling adds geometric tails on top of that.
	localparam int QUIET_LIMIT = 2000;

	// One command waiting to be presented on the input channel.
	typedef struct {
		logic [1:0]              cmd;
		logic signed [KEY_W-1:0] key;
	} slk_command_t;

	// One output item as the unit should produce it.
	typedef struct {
		logic [KEY_W-1:0] key;
		logic [2:0]       status;
		logic             is_entry;
		logic             last;
	} slk_result_t;

	logic                    clk       = 1'b0;
	logic                    arst_n    = 1'b0;
	logic                    in_valid  = 1'b0;
	logic                    in_ready;
	logic [1:0]              command   = CMD_INSERT;
	logic signed [KEY_W-1:0] key       = '0;
	logic                    out_valid;
	logic                    out_ready = 1'b0;
	logic signed [KEY_W-1:0] out_key;
	logic [2:0]              status;
	logic                    is_entry;
	logic                    last;

	// Commands not yet presented, results not yet seen, and the ordered shadow of the table.
	slk_command_t            pending_commands[$];
	slk_result_t             awaited_results[$];
	logic signed [KEY_W-1:0] shadow_keys[$];

	// Keys the stimulus believes are stored, so that deletes often hit something.
	logic signed [KEY_W-1:0] inserted_pool[$];

	int send_idle_pct  = 0;
	int recv_stall_pct = 0;
	int mismatch_count = 0;
	int quiet_cycles   = 0;

	slk_command_t next_command;
	slk_result_t  oldest_result;

	sorted_key_list_unit u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.command   (command),
		.key       (key),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_key   (out_key),
		.status    (status),
		.is_entry  (is_entry),
		.last      (last)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	task automatic flag_mismatch(input string msg);
		$display("MISMATCH at %0t: %s", $realtime, msg);
		mismatch_count++;
	endtask

	function automatic void expect_item(input logic [KEY_W-1:0] k, input logic [2:0] st,
			input logic entry, input logic fin);
		slk_result_t r;
		r.key      = k;
		r.status   = st;
		r.is_entry = entry;
		r.last     = fin;
		awaited_results.push_back(r);
	endfunction

	// Applies one accepted command to the shadow table and queues the items it must produce.
	// Inserts go in front of the first stored key that is not smaller, so equal keys stay
	// grouped; a delete removes the first equal entry. Listings walk the shadow in either
	// direction and mark the final entry; an empty table lists as a single empty item.
	task automatic predict_list_response(input logic [1:0] cmd, input logic signed [KEY_W-1:0] k);
		int pos;
		int n;
		n   = shadow_keys.size();
		pos = 0;
		case (cmd)
			CMD_INSERT: begin
				if (n >= CAPACITY) begin
					expect_item(k, ST_FULL, 1'b0, 1'b1);
				end else begin
					while (pos < n && shadow_keys[pos] < k)
						pos++;
					shadow_keys.insert(pos, k);
					expect_item(k, ST_INSERTED, 1'b0, 1'b1);
				end
			end
			CMD_DELETE: begin
				while (pos < n && shadow_keys[pos] != k)
					pos++;
				if (pos >= n) begin
					expect_item(k, ST_NOT_FOUND, 1'b0, 1'b1);
				end else begin
					shadow_keys.delete(pos);
					expect_item(k, ST_DELETED, 1'b0, 1'b1);
				end
			end
			default: begin
				if (n == 0) begin
					expect_item('0, ST_EMPTY, 1'b0, 1'b1);
				end else begin
					for (int i = 0; i < n; i++)
						expect_item((cmd == CMD_LIST_UP) ? shadow_keys[i] : shadow_keys[n - 1 - i],
							ST_INSERTED, 1'b1, (i == n - 1));
				end
			end
		endcase
	endtask

	// Driver: presents the next pending command, holding it until it is accepted. The valid
	// output is only reassigned when it is free or taken, so a back-to-back item never drops valid.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			command  <= CMD_INSERT;
			key      <= '0;
		end else begin
			if (in_valid && in_ready)
				predict_list_response(command, key);
			if (!in_valid || in_ready) begin
				if (pending_commands.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
					next_command = pending_commands.pop_front();
					in_valid <= 1'b1;
					command  <= next_command.cmd;
					key      <= next_command.key;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Monitor: checks each accepted output item against the oldest awaited result and
	// toggles out_ready at random according to the current stall rate.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				if (awaited_results.size() == 0) begin
					flag_mismatch($sformatf("unexpected item: key %0d status %0d entry %0b last %0b",
						out_key, status, is_entry, last));
				end else begin
					oldest_result = awaited_results.pop_front();
					if (out_key !== oldest_result.key)
						flag_mismatch($sformatf("out_key %0d, expected %0d",
							out_key, $signed(oldest_result.key)));
					if (status !== oldest_result.status)
						flag_mismatch($sformatf("status %0d, expected %0d (key %0d)",
							status, oldest_result.status, $signed(oldest_result.key)));
					if (is_entry !== oldest_result.is_entry)
						flag_mismatch($sformatf("is_entry %0b, expected %0b (key %0d)",
							is_entry, oldest_result.is_entry, $signed(oldest_result.key)));
					if (last !== oldest_result.last)
						flag_mismatch($sformatf("last %0b, expected %0b (key %0d)",
							last, oldest_result.last, $signed(oldest_result.key)));
				end
			end
			out_ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// Watchdog: a correct run never goes this long without moving an item on either side.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("Some tests failed");
				$finish;
			end
		end
	end

	function automatic void queue_command(input logic [1:0] cmd, input logic signed [KEY_W-1:0] k);
		slk_command_t c;
		c.cmd = cmd;
		c.key = k;
		pending_commands.push_back(c);
	endfunction

	// Keys mix the extremes, a narrow band around zero (plenty of duplicates) and full-width
	// random patterns so that every key bit sees both values.
	function automatic logic signed [KEY_W-1:0] pick_key();
		int r;
		r = $urandom_range(99);
		if (r < 15) begin
			case ($urandom_range(3))
				0: return {1'b1, {(KEY_W-1){1'b0}}};
				1: return {1'b0, {(KEY_W-1){1'b1}}};
				2: return '0;
				default: return '1;
			endcase
		end
		if (r < 50)
			return $signed($urandom_range(16)) - 8;
		return $urandom;
	endfunction

	// Random commands with the given insert and delete shares; the rest are listings in
	// either direction. Most deletes aim at a key that was inserted earlier.
	task automatic queue_random(input int count, input int ins_pct, input int del_pct);
		int r;
		int idx;
		logic signed [KEY_W-1:0] k;
		for (int i = 0; i < count; i++) begin
			r = $urandom_range(99);
			if (r < ins_pct) begin
				k = pick_key();
				queue_command(CMD_INSERT, k);
				if (inserted_pool.size() < CAPACITY)
					inserted_pool.push_back(k);
			end else if (r < ins_pct + del_pct) begin
				if (inserted_pool.size() > 0 && $urandom_range(99) < 65) begin
					idx = $urandom_range(inserted_pool.size() - 1);
					k   = inserted_pool[idx];
					inserted_pool.delete(idx);
				end else begin
					k = pick_key();
				end
				queue_command(CMD_DELETE, k);
			end else begin
				queue_command($urandom_range(1) ? CMD_LIST_UP : CMD_LIST_DOWN, $urandom);
			end
		end
	endtask

	// Waits until every queued command has been taken and every awaited item has arrived.
	task automatic wait_drained();
		while (pending_commands.size() > 0 || in_valid || awaited_results.size() > 0)
			@(negedge clk);
	endtask

	initial begin
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed: empty listings, a delete with nothing stored, the key extremes, a duplicate,
		// both listing orders on a populated table, deletes of duplicates and of absent keys,
		// alternating bit patterns, and finally emptying the table again.
		queue_command(CMD_LIST_UP,   '0);
		queue_command(CMD_LIST_DOWN, '1);
		queue_command(CMD_DELETE,    5);
		queue_command(CMD_INSERT,    {1'b0, {(KEY_W-1){1'b1}}});
		queue_command(CMD_INSERT,    {1'b1, {(KEY_W-1){1'b0}}});
		queue_command(CMD_INSERT,    0);
		queue_command(CMD_INSERT,    -1);
		queue_command(CMD_INSERT,    0);
		queue_command(CMD_INSERT,    1);
		queue_command(CMD_LIST_UP,   '0);
		queue_command(CMD_LIST_DOWN, '0);
		queue_command(CMD_DELETE,    0);
		queue_command(CMD_DELETE,    7);
		queue_command(CMD_DELETE,    {1'b1, {(KEY_W-1){1'b0}}});
		queue_command(CMD_DELETE,    {1'b0, {(KEY_W-1){1'b1}}});
		queue_command(CMD_LIST_UP,   {1'b0, {(KEY_W-1){1'b1}}});
		queue_command(CMD_INSERT,    32'h5555_5555);
		queue_command(CMD_INSERT,    32'hAAAA_AAAA);
		queue_command(CMD_LIST_DOWN, -1);
		queue_command(CMD_DELETE,    -1);
		queue_command(CMD_DELETE,    0);
		queue_command(CMD_DELETE,    1);
		queue_command(CMD_DELETE,    32'h5555_5555);
		queue_command(CMD_DELETE,    32'hAAAA_AAAA);
		queue_command(CMD_LIST_UP,   '1);
		wait_drained();

		// Fill phase without idling, then keep inserting with a slow sender until the table
		// is full and inserts start bouncing.
		queue_random(70, 70, 10);
		wait_drained();
		send_idle_pct = 63;
		queue_random(60, 75, 5);
		wait_drained();

		// Drain with long listings against a slow receiver, then a mixed phase with both idling.
		send_idle_pct  = 0;
		recv_stall_pct = 63;
		queue_random(65, 15, 60);
		wait_drained();
		send_idle_pct  = 27;
		recv_stall_pct = 27;
		queue_random(65, 45, 35);
		wait_drained();

		// A listing can still be turning the ring after its last item; catch any stray output.
		repeat (2 * CAPACITY + 10) @(negedge clk);
		if (awaited_results.size() > 0)
			flag_mismatch($sformatf("%0d items never arrived", awaited_results.size()));

		if (mismatch_count == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule

FILE: sorted_key_list_unit.f
hw/rtl/slk_pkg.sv
hw/rtl/slk_cell.sv
hw/rtl/slk_ctrl.sv
hw/rtl/sorted_key_list_unit.sv
tb/sv/sorted_key_list_unit_test.sv
